// ===== hw/rtl/rbf_pkg.sv =====
// Shared constants and types for the Gaussian RBF network evaluator.
package rbf_pkg;

    localparam int NUM_KERNELS = 16;
    localparam int KCNT_W      = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;

    // exp(-a/64) table, unsigned Q0.16
    localparam int ROM_SIZE = 1024;
    localparam int ROM_AW   = 10;
    localparam int EXP_W    = 16;
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4228380000;

    localparam logic [15:0] INV_WIDTH_RESET = 16'd6400;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam int TERM_W = 32;
    localparam int OUT_W  = 24;
    localparam int ACC_W  = (TERM_W + KCNT_W + 1 > OUT_W + 17) ?
                            (TERM_W + KCNT_W + 1) : (OUT_W + 17);

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] w;
    } kernel_t;

endpackage

// ===== hw/rtl/gaussian_rbf_network_eval_unit.sv =====
// Top level of the Gaussian RBF network evaluator: cell ring and kernel datapath.
//
// Usage:
//  - Command channel: a request transfers on a rising edge with start high and
//    busy low. req_type selects a load (write center_x, center_y, weight into
//    slot kernel_index) or an evaluate (inputs in_x, in_y).
//  - A load finishes in its own cycle and gives no result; loads may follow
//    each other back to back. Slots at or past NUM_KERNELS are ignored.
//  - An evaluate rotates the kernel ring once, one kernel per cycle into the
//    datapath; result_valid pulses for one cycle once the last kernel has
//    passed the datapath stages and the accumulator, and busy drops the cycle
//    after. No request is taken while busy is high, so a new evaluate starts
//    only after the last one has given its result.
//  - Result: network_out is valid only while result_valid is high; the
//    receiver has no stall, each result is taken in its strobe cycle.
//  - Config: inv_width is written by a cfg_valid/cfg_ready transfer
//    (cfg_ready is always high); write it only while busy is low.
//  - Reset: kernels clear to zero, inv_width to 25.0. The exp table is then
//    rebuilt entry by entry, and busy stays high until the rebuild is done.
module gaussian_rbf_network_eval_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic [3:0]                kernel_index,
    input  logic signed [15:0]        center_x,
    input  logic signed [15:0]        center_y,
    input  logic signed [15:0]        weight,
    input  logic signed [15:0]        in_x,
    input  logic signed [15:0]        in_y,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data,
    output logic                      result_valid,
    output logic signed [23:0]        network_out
);

    import rbf_pkg::*;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN
    } state_t;

    // per-item tags that ride along the datapath stages
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

    localparam int QW = ACC_W - 15;

    state_t              state_reg;
    logic [KCNT_W-1:0]   cnt_reg;
    logic signed [15:0]  x_reg;
    logic signed [15:0]  y_reg;
    logic [15:0]         inv_width_reg;

    logic                table_ready;
    logic [EXP_W-1:0]    exp_data;

    logic                accept;
    logic                load_fire;
    logic                shift_en;
    kernel_t             load_data;
    kernel_t             cell_data [NUM_KERNELS];

    // ---------------- control ----------------
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign load_fire = accept && (req_type == REQ_LOAD) &&
                       (32'(kernel_index) < NUM_KERNELS);
    assign shift_en  = (state_reg == ST_EVAL);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    if (table_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (req_type == REQ_EVAL))
                    begin
                        state_reg <= ST_EVAL;
                        cnt_reg   <= '0;
                    end
                end
                ST_EVAL:
                begin
                    if (cnt_reg == KCNT_W'(NUM_KERNELS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DRAIN:
                begin
                    if (result_valid)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_EVAL))
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_width_reg <= INV_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            inv_width_reg <= cfg_data;
        end
    end

    // ---------------- kernel ring ----------------
    // Cell 0 is the head; every evaluate shifts the ring NUM_KERNELS times,
    // so each kernel passes the head once and ends in its own slot.
    assign load_data = '{cx: center_x, cy: center_y, w: weight};

    for (genvar k = 0; k < NUM_KERNELS; k++)
    begin : g_cell
        rbf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (load_fire && (32'(kernel_index) == k)),
            .load_data (load_data),
            .shift_en  (shift_en),
            .shift_in  (cell_data[(k + 1) % NUM_KERNELS]),
            .data      (cell_data[k])
        );
    end

    // ---------------- kernel datapath ----------------
    tag_t               tag0;
    tag_t               s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    tag_t               s5_tag_reg, s6_tag_reg;
    logic signed [16:0] s1_dx_reg, s1_dy_reg;
    logic signed [15:0] s1_w_reg, s2_w_reg, s3_w_reg, s4_w_reg, s5_w_reg;
    logic [31:0]        s2_sqx_reg, s2_sqy_reg;
    logic [32:0]        s3_d2_reg;
    logic [ROM_AW-1:0]  s4_addr_reg;
    logic               s4_far_reg, s5_far_reg;
    logic signed [TERM_W-1:0] s6_term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic               acc_done_reg;

    logic signed [33:0] sqx_full, sqy_full;
    logic [48:0]        p_full;
    logic [EXP_W-1:0]   e_eff;
    logic signed [32:0] term_full;
    logic signed [ACC_W-1:0] term_ext;
    logic signed [ACC_W:0]   t_full;
    logic signed [QW-1:0]    q;
    logic               q_fits;
    logic signed [OUT_W-1:0] q_sat;

    assign tag0 = '{valid: shift_en,
                    first: (cnt_reg == '0),
                    last:  (cnt_reg == KCNT_W'(NUM_KERNELS - 1))};

    assign sqx_full = s1_dx_reg * s1_dx_reg;
    assign sqy_full = s1_dy_reg * s1_dy_reg;
    // argument a = (d2 * inv_width) >> 26; 16.0 or more reads as zero
    assign p_full   = s3_d2_reg * inv_width_reg;
    assign e_eff    = s5_far_reg ? '0 : exp_data;
    assign term_full = s5_w_reg * $signed({1'b0, e_eff});
    assign term_ext = {{(ACC_W - TERM_W){s6_term_reg[TERM_W-1]}}, s6_term_reg};

    // round half up, floor shift, then clamp to Q14.10
    assign t_full = {acc_reg[ACC_W-1], acc_reg} + (ACC_W + 1)'(32768);
    assign q      = t_full[ACC_W:16];
    assign q_fits = (q[QW-1:OUT_W-1] == '0) || (q[QW-1:OUT_W-1] == '1);
    assign q_sat  = q_fits ? q[OUT_W-1:0] :
                    (q[QW-1] ? {1'b1, {(OUT_W - 1){1'b0}}} :
                               {1'b0, {(OUT_W - 1){1'b1}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg   <= '0;
            s2_tag_reg   <= '0;
            s3_tag_reg   <= '0;
            s4_tag_reg   <= '0;
            s5_tag_reg   <= '0;
            s6_tag_reg   <= '0;
            acc_done_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            s1_tag_reg   <= tag0;
            s2_tag_reg   <= s1_tag_reg;
            s3_tag_reg   <= s2_tag_reg;
            s4_tag_reg   <= s3_tag_reg;
            s5_tag_reg   <= s4_tag_reg;
            s6_tag_reg   <= s5_tag_reg;
            acc_done_reg <= s6_tag_reg.valid && s6_tag_reg.last;
            result_valid <= acc_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= {x_reg[15], x_reg} - {cell_data[0].cx[15], cell_data[0].cx};
        s1_dy_reg   <= {y_reg[15], y_reg} - {cell_data[0].cy[15], cell_data[0].cy};
        s1_w_reg    <= cell_data[0].w;

        s2_sqx_reg  <= sqx_full[31:0];
        s2_sqy_reg  <= sqy_full[31:0];
        s2_w_reg    <= s1_w_reg;

        s3_d2_reg   <= {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
        s3_w_reg    <= s2_w_reg;

        s4_addr_reg <= p_full[35:26];
        s4_far_reg  <= |p_full[48:36];
        s4_w_reg    <= s3_w_reg;

        s5_far_reg  <= s4_far_reg;
        s5_w_reg    <= s4_w_reg;

        s6_term_reg <= term_full[TERM_W-1:0];

        if (s6_tag_reg.valid)
        begin
            acc_reg <= s6_tag_reg.first ? term_ext : acc_reg + term_ext;
        end

        if (acc_done_reg)
        begin
            network_out <= q_sat;
        end
    end

    rbf_exp_table u_exp_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (s4_addr_reg),
        .rd_data (exp_data),
        .ready   (table_ready)
    );

endmodule

// ===== hw/rtl/rbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rbf_cell.sv =====
// One kernel cell of the rotating ring: holds a center and a weight.
module rbf_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_en,
    input  rbf_pkg::kernel_t load_data,
    input  logic             shift_en,
    input  rbf_pkg::kernel_t shift_in,
    output rbf_pkg::kernel_t data
);

    import rbf_pkg::*;

    kernel_t data_reg;
    kernel_t data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (load_en)
        begin
            data_next = load_data;
        end
        else if (shift_en)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/rbf_exp_table.sv =====
// Exponential lookup table: built after reset by recurrence, then read-only.
module rbf_exp_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rbf_pkg::ROM_AW-1:0] rd_addr,
    output logic [rbf_pkg::EXP_W-1:0]  rd_data,
    output logic                       ready
);

    import rbf_pkg::*;

    logic [ROM_AW-1:0] fill_addr_reg;
    logic              phase_reg;
    logic              done_reg;
    logic [32:0]       r_reg;      // running exp value, unsigned Q1.32
    logic [47:0]       plo_reg;
    logic [48:0]       phi_reg;

    logic [33:0]       rnd;
    logic [EXP_W-1:0]  wdata;
    logic [65:0]       sum;
    logic              we;

    assign rnd   = {1'b0, r_reg} + 34'd32768;
    assign wdata = (|rnd[33:32]) ? {EXP_W{1'b1}} : rnd[31:16];
    assign sum   = {1'b0, phi_reg, 16'b0} + {18'b0, plo_reg} + (66'd1 << 31);
    assign we    = !done_reg && !phase_reg;

    // phase 0: write entry, form partial products; phase 1: new r
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_addr_reg <= '0;
            phase_reg     <= 1'b0;
            done_reg      <= 1'b0;
            r_reg         <= 33'h1_0000_0000;
        end
        else if (!done_reg)
        begin
            if (!phase_reg)
            begin
                if (fill_addr_reg == ROM_AW'(ROM_SIZE - 1))
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b1;
                end
            end
            else
            begin
                r_reg         <= sum[64:32];
                fill_addr_reg <= fill_addr_reg + 1'b1;
                phase_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= r_reg[15:0] * EXP_STEP_Q32;
        phi_reg <= r_reg[32:16] * EXP_STEP_Q32;
    end

    rbf_ram #(
        .WIDTH (EXP_W),
        .DEPTH (ROM_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (fill_addr_reg),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign ready = done_reg;

endmodule

// ===== dv/tb_gaussian_rbf_network_eval_unit.sv =====
// Testbench for the Gaussian RBF network evaluator: random and directed loads and evaluates.
module tb_gaussian_rbf_network_eval_unit;

    import rbf_pkg::*;

    // Settle time after the last result before a register write or the end of the run;
    // it is longer than a whole evaluate, so it covers any work still in flight.
    localparam int DRAIN_CYCLES = NUM_KERNELS + 16;
    localparam int MAX_GAP      = 19;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               req_type;
    logic [3:0]         kernel_index;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] weight;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               result_valid;
    logic signed [23:0] network_out;

    // Predictor state: exp(-a/64) table, kernel file, and the width register.
    int unsigned        exp_rom_model [ROM_SIZE];
    kernel_t            kernel_file [NUM_KERNELS];
    logic [15:0]        inv_width_model;

    // Evaluate results still owed by the block, oldest first.
    logic signed [23:0] pending_sums [$];
    logic signed [23:0] oldest_sum;

    int                 err_count = 0;
    int                 gap_limit = MAX_GAP;

    gaussian_rbf_network_eval_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .kernel_index (kernel_index),
        .center_x     (center_x),
        .center_y     (center_y),
        .weight       (weight),
        .in_x         (in_x),
        .in_y         (in_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .network_out  (network_out)
    );

    always #10 clk = ~clk;

    // Run limit: reset table rebuild plus ~750 items at worst (widest gap and a full
    // evaluate each) plus drains, taken several times over.
    initial
    begin
        #(20 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Table of exp(-i/64), Q0.16: a Q1.32 running value, stepped by exp(-1/64)
    // with round-half-up; entry 0 would be 1.0 and clips to 65535.
    function automatic void build_exp_rom();
        longint unsigned r;
        longint unsigned v;
        int              i;
        r = 64'd1 << 32;
        for (i = 0; i < ROM_SIZE; i++)
        begin
            v = (r + 64'd32768) >> 16;
            exp_rom_model[i] = (v > 64'd65535) ? 65535 : int'(v);
            r = (r * 64'(EXP_STEP_Q32) + (64'd1 << 31)) >> 32;
        end
    endfunction

    // Weighted kernel sum for one evaluate. Every product and the sum are exact;
    // the Q10.26 sum rounds half up to Q14.10 (floor shift) and then clips.
    function automatic logic signed [23:0] rbf_network_sum(logic signed [15:0] x,
                                                           logic signed [15:0] y);
        longint          acc;
        longint          dx;
        longint          dy;
        longint          q;
        longint unsigned d2;
        longint unsigned arg;
        longint          e;
        int              k;
        acc = 0;
        for (k = 0; k < NUM_KERNELS; k++)
        begin
            dx  = longint'(x) - longint'(kernel_file[k].cx);
            dy  = longint'(y) - longint'(kernel_file[k].cy);
            d2  = unsigned'(dx * dx + dy * dy);
            arg = (d2 * 64'(inv_width_model)) >> 26;
            // argument of 16.0 or more falls off the table and reads as zero
            e   = (arg >= ROM_SIZE) ? 0 : longint'(exp_rom_model[arg]);
            acc += longint'(kernel_file[k].w) * e;
        end
        q = (acc + 32768) >>> 16;
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        if (q < -64'sd8388608)
            q = -64'sd8388608;
        return q[23:0];
    endfunction

    // ------------------------------------------------------------------
    // Result checker: the strobe lasts one cycle and cannot be held off,
    // so it is sampled mid-cycle, away from the driving edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("network_out: no result expected, got %0d", network_out);
                err_count++;
            end
            else
            begin
                oldest_sum = pending_sums.pop_front();
                if (network_out !== oldest_sum)
                begin
                    $error("network_out: expected %0d, actual %0d", oldest_sum, network_out);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One command transfer. Entered and left at a rising edge; start stays high
    // when the next item follows with no gap.
    task automatic send_item(input logic rtype, input logic [3:0] idx,
                             input logic signed [15:0] cx, input logic signed [15:0] cy,
                             input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y);
        int gap;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= rtype;
        kernel_index <= idx;
        center_x     <= cx;
        center_y     <= cy;
        weight       <= w;
        in_x         <= x;
        in_y         <= y;
        // busy only moves on a rising edge, so its mid-cycle value decides the next edge
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
        // transfer done at this edge
        if (rtype == REQ_LOAD)
        begin
            if (int'(idx) < NUM_KERNELS)
                kernel_file[idx] = '{cx: cx, cy: cy, w: w};
        end
        else
            pending_sums.push_back(rbf_network_sum(x, y));
    endtask

    // Load carries random junk on the evaluate-only fields.
    task automatic load_kernel(input logic [3:0] idx, input logic signed [15:0] cx,
                               input logic signed [15:0] cy, input logic signed [15:0] w);
        send_item(REQ_LOAD, idx, cx, cy, w, 16'($urandom), 16'($urandom));
    endtask

    // Evaluate carries random junk on the load-only fields.
    task automatic eval_point(input logic signed [15:0] x, input logic signed [15:0] y);
        send_item(REQ_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), x, y);
    endtask

    // Quiet the command channel, collect every owed result, then let the block drain.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
    endtask

    // Register write through its own valid/ready channel, only with the block idle.
    task automatic write_inv_width(input logic [15:0] value);
        int gap;
        wait_idle();
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0)
            repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (cfg_ready !== 1'b1);
        @(posedge clk);
        inv_width_model = value;
        cfg_valid <= 1'b0;
    endtask

    // Centers mostly near the origin so evaluates land inside kernels; some anywhere.
    function automatic logic signed [15:0] random_center();
        logic signed [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 9) < 7)
            v = v >>> 2;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh kernel file has all weights zero: every evaluate must give zero.
    task automatic test_reset_state();
        eval_point(16'sd0, 16'sd0);
        eval_point(-16'sd32768, 16'sd32767);
    endtask

    // Zero distance hits the clipped table entry; a far corner falls off the table.
    task automatic test_zero_distance_and_far_inputs();
        load_kernel(4'd0, 16'sd0, 16'sd0, 16'sd32767);
        eval_point(16'sd0, 16'sd0);
        load_kernel(4'd15, -16'sd32768, -16'sd32768, -16'sd32768);
        eval_point(-16'sd32768, -16'sd32768);
        eval_point(16'sd32767, 16'sd32767);
        load_kernel(4'd5, 16'sd32767, -16'sd1, 16'sd1);
        eval_point(16'sd32767, -16'sd1);
    endtask

    // Width register at both ends: zero makes every kernel read entry 0,
    // full scale makes kernels very narrow.
    task automatic test_width_extremes();
        write_inv_width(16'd0);
        eval_point(16'sd32767, -16'sd32768);
        eval_point(16'sd12345, 16'sd0);
        write_inv_width(16'hFFFF);
        eval_point(16'sd1, 16'sd0);
        eval_point(16'sd0, -16'sd200);
        write_inv_width(INV_WIDTH_RESET);
    endtask

    // One random phase at a given width: refill all kernels, then a mix of loads,
    // evaluates aimed near a stored center at assorted spans, and wild evaluates.
    task automatic run_random_phase(input logic [15:0] width, input int n_items,
                                    input int max_gap, input bit extreme_weights);
        int                 i;
        int                 k;
        int                 span;
        int                 off_x;
        int                 off_y;
        int                 pick;
        logic signed [15:0] w;
        write_inv_width(width);
        gap_limit = max_gap;
        for (k = 0; k < NUM_KERNELS; k++)
        begin
            if (extreme_weights)
                w = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            else
                w = 16'($urandom);
            load_kernel(4'(k), random_center(), random_center(), w);
        end
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                load_kernel(4'($urandom), random_center(), random_center(), 16'($urandom));
            else if (pick < 8)
            begin
                k     = $urandom_range(0, NUM_KERNELS - 1);
                span  = 1 << $urandom_range(0, 13);
                off_x = int'($urandom_range(0, 2 * span)) - span;
                off_y = int'($urandom_range(0, 2 * span)) - span;
                eval_point(16'(int'(kernel_file[k].cx) + off_x),
                           16'(int'(kernel_file[k].cy) + off_y));
            end
            else
                eval_point(16'($urandom), 16'($urandom));
        end
        gap_limit = MAX_GAP;
    endtask

    task automatic test_random_traffic();
        run_random_phase(INV_WIDTH_RESET, 130, MAX_GAP, 1'b0);
        run_random_phase(16'hFFFF, 90, MAX_GAP, 1'b0);
        run_random_phase(16'd0, 50, MAX_GAP, 1'b1);
        // back-to-back stretch: start held high across items
        run_random_phase(16'd256, 110, 0, 1'b0);
        run_random_phase(16'd1, 70, MAX_GAP, 1'b0);
        run_random_phase(16'($urandom), 100, MAX_GAP, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        build_exp_rom();
        inv_width_model = INV_WIDTH_RESET;
        for (i = 0; i < NUM_KERNELS; i++)
            kernel_file[i] = '0;

        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_LOAD;
        kernel_index = '0;
        center_x     = '0;
        center_y     = '0;
        weight       = '0;
        in_x         = '0;
        in_y         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first transfer waits out the table rebuild through busy.
        test_reset_state();
        test_zero_distance_and_far_inputs();
        test_width_extremes();
        test_random_traffic();

        // Drain: collect owed results with a bound, then let the pipeline settle.
        start <= 1'b0;
        for (i = 0; i < 2000 && pending_sums.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_sums.size() != 0)
        begin
            $error("network_out: %0d expected results never arrived", pending_sums.size());
            err_count++;
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rbf_pkg.sv
hw/rtl/rbf_ram.sv
hw/rtl/rbf_cell.sv
hw/rtl/rbf_exp_table.sv
hw/rtl/gaussian_rbf_network_eval_unit.sv
dv/tb_gaussian_rbf_network_eval_unit.sv
